// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each check is sampled on the rising clock edge and is held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Types, tables and constants for the MPEG audio header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

	localparam logic [31:0] SYNC_MASK = 32'hffe0_0000;

	// quotient bits of the frame length divide, one per cell
	localparam int QBITS    = 12;
	localparam int NUM_W    = 26;
	localparam int DVS_W    = 16;
	// start to done: two decode stages, one stage per cell, output register
	localparam int DONE_LAT = QBITS + 3;

	localparam logic [17:0] MUL_L1  = 18'd12000;
	localparam logic [17:0] MUL_L23 = 18'd144000;

	localparam logic [15:0] BASE_RATE [0:2] = '{16'd44100, 16'd48000, 16'd32000};

	// [lsf][layer-1][bitrate index]
	localparam logic [8:0] KBPS_TBL [0:1][0:2][0:14] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
				9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
				9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
		}
	};

	// decoded fields riding alongside the divide
	typedef struct packed {
		logic        ok;
		logic        free_fmt;
		logic        l1;
		logic        pad;
		logic [1:0]  version;
		logic [1:0]  layer_number;
		logic [15:0] fs_hz;
		logic [3:0]  rate_index;
		logic        crc_present;
		logic [8:0]  bitrate_kbps;
		logic [1:0]  chan_mode;
		logic [1:0]  stereo_ext;
		logic [1:0]  channel_count;
	} hdr_info_t;

	// partial state of the restoring divide
	typedef struct packed {
		logic [DVS_W-1:0] rem;
		logic [QBITS-1:0] low;
		logic [QBITS-1:0] quo;
		logic [DVS_W-1:0] dvs;
	} div_word_t;

endpackage

// ===== design/mahd_field_decode.sv =====
// ----------------------------------------------------------------------------
// mahd_field_decode
// Header checks and field decode, then dividend and divisor set-up.
// ----------------------------------------------------------------------------
module mahd_field_decode import mahd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_vld,
	input  logic [31:0] hdr,
	output logic       out_vld,
	output hdr_info_t  out_info,
	output div_word_t  out_word
);

	logic [1:0]  layer_code;
	logic [3:0]  br_idx;
	logic [1:0]  sr_idx;
	logic        ok;
	logic        lsf;
	logic [1:0]  shift;
	logic [1:0]  layer;
	logic [1:0]  layer_m1;
	logic [15:0] sr;
	logic [8:0]  kbps;
	hdr_info_t   info_d;
	logic        vld_s1;
	hdr_info_t   info_s1;
	logic [DVS_W-1:0] dvs_d;
	logic [DVS_W-1:0] dvs_s1;
	logic [26:0] prod;
	logic [NUM_W-1:0] num;
	logic        vld_s2;
	hdr_info_t   info_s2;
	div_word_t   word_s2;

	assign layer_code = hdr[18:17];
	assign br_idx     = hdr[15:12];
	assign sr_idx     = hdr[11:10];

	assign ok = ((hdr & SYNC_MASK) == SYNC_MASK) && (layer_code != 2'd0) &&
		(br_idx != 4'd15) && (sr_idx != 2'd3);

	always_comb begin
		if (hdr[20]) begin
			lsf   = ~hdr[19];
			shift = {1'b0, ~hdr[19]};
		end else begin
			lsf   = 1'b1;
			shift = 2'd2;
		end
	end

	assign layer    = 2'(3'd4 - {1'b0, layer_code});
	assign layer_m1 = 2'd3 - layer_code;
	assign sr       = (sr_idx == 2'd3) ? 16'd0 : (BASE_RATE[sr_idx] >> shift);
	assign kbps     = (br_idx == 4'd15 || layer_code == 2'd0) ? 9'd0 :
		KBPS_TBL[lsf][layer_m1][br_idx];

	always_comb begin
		info_d = '0;
		dvs_d  = '0;
		if (ok) begin
			info_d.ok             = 1'b1;
			info_d.free_fmt       = (br_idx == 4'd0);
			info_d.l1             = (layer == 2'd1);
			info_d.pad            = hdr[9];
			info_d.version        = shift;
			info_d.layer_number   = layer;
			info_d.fs_hz          = sr;
			info_d.rate_index     = {2'b00, sr_idx} + 4'(3 * shift);
			info_d.crc_present    = ~hdr[16];
			info_d.bitrate_kbps   = kbps;
			info_d.chan_mode      = hdr[7:6];
			info_d.stereo_ext     = hdr[5:4];
			info_d.channel_count  = (hdr[7:6] == 2'd3) ? 2'd1 : 2'd2;
			// layer 3 divides by the doubled rate on the low sample rates
			dvs_d = (layer == 2'd3) ? DVS_W'(sr << lsf) : sr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		info_s1 <= info_d;
		dvs_s1  <= dvs_d;
	end

	assign prod = info_s1.bitrate_kbps * (info_s1.l1 ? MUL_L1 : MUL_L23);
	assign num  = prod[NUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// quotient fits in QBITS, so the high part of the dividend starts below the divisor
	always_ff @(posedge clk) begin
		info_s2     <= info_s1;
		word_s2.rem <= DVS_W'(num[NUM_W-1:QBITS]);
		word_s2.low <= num[QBITS-1:0];
		word_s2.quo <= '0;
		word_s2.dvs <= dvs_s1;
	end

	assign out_vld  = vld_s2;
	assign out_info = info_s2;
	assign out_word = word_s2;

endmodule

// ===== design/mahd_div_cell.sv =====
// ----------------------------------------------------------------------------
// mahd_div_cell
// One restoring-divide cell: resolves one quotient bit and passes the item on.
// ----------------------------------------------------------------------------
module mahd_div_cell import mahd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	input  hdr_info_t in_info,
	input  div_word_t in_word,
	output logic      out_vld,
	output hdr_info_t out_info,
	output div_word_t out_word
);

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;
	logic           vld_q;
	hdr_info_t      info_q;
	div_word_t      word_q;

	assign trial = {in_word.rem, in_word.low[QBITS-1]};
	assign diff  = trial - {1'b0, in_word.dvs};
	assign ge    = (trial >= {1'b0, in_word.dvs});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	// remainder stays below the divisor, so the top bit drops
	always_ff @(posedge clk) begin
		info_q     <= in_info;
		word_q.rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		word_q.low <= {in_word.low[QBITS-2:0], 1'b0};
		word_q.quo <= {in_word.quo[QBITS-2:0], ge};
		word_q.dvs <= in_word.dvs;
	end

	assign out_vld  = vld_q;
	assign out_info = info_q;
	assign out_word = word_q;

endmodule

// ===== design/mpeg_audio_header_decode.sv =====
// ----------------------------------------------------------------------------
// mpeg_audio_header_decode
// MPEG audio frame header checker and decoder with frame length.
// ----------------------------------------------------------------------------
// A header word is taken on any cycle with start high; busy is always low, so
// a new header can enter every cycle. Each item's result appears with done
// exactly 15 cycles after start, for one cycle, and must be captured then.
// The latency is set by the frame length divide: a row of 12 cells, one per
// quotient bit, behind two decode stages and one output register.
module mpeg_audio_header_decode import mahd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] header_word,
	output logic        done,
	output logic        header_ok,
	output logic        free_format,
	output logic [1:0]  version,
	output logic [1:0]  layer_number,
	output logic [15:0] fs_hz,
	output logic [3:0]  rate_index,
	output logic        crc_present,
	output logic [8:0]  bitrate_kbps,
	output logic [1:0]  chan_mode,
	output logic [1:0]  stereo_ext,
	output logic [1:0]  channel_count,
	output logic [11:0] frame_bytes
);

	logic      vld_c  [0:QBITS];
	hdr_info_t info_c [0:QBITS];
	div_word_t word_c [0:QBITS];
	hdr_info_t fin;
	logic [QBITS:0] sum;
	logic [11:0] bytes_d;
	logic      done_q;
	hdr_info_t info_q;
	logic [11:0] bytes_q;

	assign busy = 1'b0;

	mahd_field_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.hdr      (header_word),
		.out_vld  (vld_c[0]),
		.out_info (info_c[0]),
		.out_word (word_c[0])
	);

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		mahd_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_c[i]),
			.in_info  (info_c[i]),
			.in_word  (word_c[i]),
			.out_vld  (vld_c[i+1]),
			.out_info (info_c[i+1]),
			.out_word (word_c[i+1])
		);
	end

	assign fin = info_c[QBITS];
	assign sum = {1'b0, word_c[QBITS].quo} + {{QBITS{1'b0}}, fin.pad};

	// layer 1 counts four-byte slots
	always_comb begin
		if (!fin.ok || fin.free_fmt) begin
			bytes_d = '0;
		end else if (fin.l1) begin
			bytes_d = 12'({sum, 2'b00});
		end else begin
			bytes_d = sum[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_c[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		info_q  <= fin;
		bytes_q <= bytes_d;
	end

	assign done           = done_q;
	assign header_ok      = info_q.ok;
	assign free_format    = info_q.free_fmt;
	assign version        = info_q.version;
	assign layer_number   = info_q.layer_number;
	assign fs_hz          = info_q.fs_hz;
	assign rate_index     = info_q.rate_index;
	assign crc_present    = info_q.crc_present;
	assign bitrate_kbps   = info_q.bitrate_kbps;
	assign chan_mode      = info_q.chan_mode;
	assign stereo_ext     = info_q.stereo_ext;
	assign channel_count  = info_q.channel_count;
	assign frame_bytes    = bytes_q;

endmodule

// ===== design/mahd_checker.sv =====
// ----------------------------------------------------------------------------
// mahd_checker
// Port-level checks for the MPEG audio header decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mahd_checker import mahd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        header_ok,
	input logic        free_format,
	input logic [1:0]  version,
	input logic [1:0]  layer_number,
	input logic [15:0] fs_hz,
	input logic [8:0]  bitrate_kbps,
	input logic [1:0]  channel_count,
	input logic [11:0] frame_bytes
);

	// every accepted item comes out with done
	`AST_IMPL(a_latency, start && !busy, ##(DONE_LAT) done)

	// a rejected header leaves nothing decoded
	`AST_IMPL(a_bad_zero, done && !header_ok, !free_format && version == 2'd0 && layer_number == 2'd0 && fs_hz == 16'd0 && bitrate_kbps == 9'd0 && frame_bytes == 12'd0 && channel_count == 2'd0)

	// free format has no bitrate and no length
	`AST_IMPL(a_free_fmt, done && free_format, header_ok && bitrate_kbps == 9'd0 && frame_bytes == 12'd0)

	// a good header with a bitrate always has a nonzero length and a layer
	`AST_IMPL(a_good_len, done && header_ok && !free_format, frame_bytes != 12'd0 && layer_number != 2'd0 && fs_hz != 16'd0)

endmodule

bind mpeg_audio_header_decode mahd_checker u_mahd_checker (.*);
